// ===== src/occc_pkg.sv =====
// Package for the opponent color channel converter.
// Field widths, divider sizing and the divide-by-three reciprocal.
// No dependencies.
package occc_pkg;

    localparam int CH_W      = 8;
    localparam int SUM_W     = 10;
    localparam int THR_W     = 14;
    localparam int INT_W     = 12;
    localparam int OPP_W     = 14;
    localparam int NUM_W     = 11;
    localparam int MAG_W     = 9;
    localparam int TRIPLE_W  = 11;
    localparam int REM_W     = SUM_W;
    localparam int FRAC_SH   = 4;
    localparam int LOW_SH    = 11;
    localparam int RECIP3_W  = 16;
    localparam int RECIP3_SH = 17;
    localparam int PROD_W    = THR_W + RECIP3_W;
    localparam int NUM_CH    = 4;

    localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [OPP_W-1:0] low;
        logic [SUM_W-1:0] div;
        logic             zero;
    } t_div_in;

endpackage

// ===== src/occc_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on occc_pkg for widths and the stage input struct.
module occc_divider (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  occc_pkg::t_div_in            i_div_in,
    output logic [occc_pkg::OPP_W-1:0]   o_quot
);
    import occc_pkg::*;

    localparam int STAGES = OPP_W;

    t_div_in          r_st [STAGES-1];
    logic [OPP_W-1:0] r_q  [STAGES];
    logic             r_zero_out;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        t_div_in          w_src;
        logic [OPP_W-1:0] w_q_src;
        logic [REM_W:0]   w_cat;
        logic [REM_W+1:0] w_diff;
        logic             w_bit;
        logic [REM_W-1:0] w_rem;

        if (k == 0) begin : g_first
            assign w_src   = i_div_in;
            assign w_q_src = '0;
        end else begin : g_next
            assign w_src   = r_st[k-1];
            assign w_q_src = r_q[k-1];
        end

        assign w_cat  = {w_src.rem, w_src.low[OPP_W-1]};
        assign w_diff = {1'b0, w_cat} - {2'b00, w_src.div};
        assign w_bit  = !w_diff[REM_W+1];
        assign w_rem  = w_bit ? w_diff[REM_W-1:0] : w_cat[REM_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k] <= {w_q_src[OPP_W-2:0], w_bit};
            end
        end

        if (k < STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k] <= '{rem:  w_rem,
                                 low:  {w_src.low[OPP_W-2:0], 1'b0},
                                 div:  w_src.div,
                                 zero: w_src.zero};
                end
            end
        end else begin : g_last
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero_out <= w_src.zero;
                end
            end
        end
    end

    assign o_quot = r_zero_out ? '0 : r_q[STAGES-1];

endmodule

// ===== src/opponent_color_channel_convert.sv =====
// Opponent color channel converter: intensity plus R, G, B, Y opponent channels.
// Depends on occc_pkg and occc_divider.
// Throughput one item per cycle while no result waits on the output; items pass stage A, stage B, then the dividers.
// The four quotients come from 14-stage divider pipelines, one quotient bit per stage.
// Stalls hold the whole pipeline while a result waits on the output.
// Reset (synchronous, active low) clears valid bits and the threshold to zero.
module opponent_color_channel_convert (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [occc_pkg::THR_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [occc_pkg::CH_W-1:0]   i_red_in,
    input  logic [occc_pkg::CH_W-1:0]   i_green_in,
    input  logic [occc_pkg::CH_W-1:0]   i_blue_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [occc_pkg::INT_W-1:0]  o_intensity_out,
    output logic [occc_pkg::OPP_W-1:0]  o_red_opp,
    output logic [occc_pkg::OPP_W-1:0]  o_green_opp,
    output logic [occc_pkg::OPP_W-1:0]  o_blue_opp,
    output logic [occc_pkg::OPP_W-1:0]  o_yellow_opp
);
    import occc_pkg::*;

    localparam int DIV_STAGES = OPP_W;
    localparam int DEPTH      = 2 + DIV_STAGES;
    localparam int CH_RED     = 0;
    localparam int CH_GREEN   = 1;
    localparam int CH_BLUE    = 2;
    localparam int CH_YELLOW  = 3;

    logic                         w_en;
    logic [DEPTH-1:0]             r_vld;
    logic [THR_W-1:0]             r_thr;

    logic [CH_W-1:0]              w_min;
    logic [SUM_W-1:0]             w_sum;
    logic [NUM_CH-1:0][NUM_W-1:0] w_num;

    logic [SUM_W-1:0]             r_a_sum;
    logic [NUM_CH-1:0][NUM_W-1:0] r_a_num;

    logic [THR_W-1:0]             w_sum16;
    logic                         w_lit;
    logic [PROD_W-1:0]            w_prod;
    t_div_in [NUM_CH-1:0]         w_div_in;

    logic [INT_W-1:0]             r_b_int;
    t_div_in [NUM_CH-1:0]         r_b_div;
    logic [INT_W-1:0]             r_int_line [DIV_STAGES];
    logic [NUM_CH-1:0][OPP_W-1:0] w_quot;

    assign w_en        = !r_vld[DEPTH-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    // stage A: channel sum and opponent numerators
    always_comb begin
        w_min = (i_red_in < i_green_in) ? i_red_in : i_green_in;
        w_sum = {2'b00, i_red_in} + {2'b00, i_green_in} + {2'b00, i_blue_in};
        w_num[CH_RED]    = {2'b00, i_red_in, 1'b0} - {3'b000, i_green_in}
                           - {3'b000, i_blue_in};
        w_num[CH_GREEN]  = {2'b00, i_green_in, 1'b0} - {3'b000, i_red_in}
                           - {3'b000, i_blue_in};
        w_num[CH_BLUE]   = {2'b00, i_blue_in, 1'b0} - {3'b000, i_red_in}
                           - {3'b000, i_green_in};
        w_num[CH_YELLOW] = {2'b00, w_min, 1'b0} - {2'b00, i_blue_in, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_sum <= w_sum;
            r_a_num <= w_num;
        end
    end

    // stage B: threshold test, intensity, divider operands
    always_comb begin
        w_sum16 = {r_a_sum, {FRAC_SH{1'b0}}};
        w_lit   = w_sum16 > r_thr;
        w_prod  = PROD_W'(w_sum16) * PROD_W'(RECIP3);
        for (int c = 0; c < NUM_CH; c++) begin
            logic [TRIPLE_W-1:0] v_triple;
            v_triple = {1'b0, r_a_num[c][MAG_W-1:0], 1'b0}
                       + TRIPLE_W'(r_a_num[c][MAG_W-1:0]);
            w_div_in[c].rem  = REM_W'(v_triple[TRIPLE_W-1:OPP_W-LOW_SH]);
            w_div_in[c].low  = {v_triple[OPP_W-LOW_SH-1:0], {LOW_SH{1'b0}}};
            w_div_in[c].div  = r_a_sum;
            w_div_in[c].zero = !w_lit || r_a_num[c][NUM_W-1] || (r_a_num[c] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_int <= w_prod[RECIP3_SH +: INT_W];
            r_b_div <= w_div_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_int_line[0] <= r_b_int;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_int_line[k] <= r_int_line[k-1];
            end
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_div
        occc_divider u_div (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_div_in (r_b_div[c]),
            .o_quot   (w_quot[c])
        );
    end

    assign o_out_valid     = r_vld[DEPTH-1];
    assign o_intensity_out = r_int_line[DIV_STAGES-1];
    assign o_red_opp       = w_quot[CH_RED];
    assign o_green_opp     = w_quot[CH_GREEN];
    assign o_blue_opp      = w_quot[CH_BLUE];
    assign o_yellow_opp    = w_quot[CH_YELLOW];

endmodule

// ===== bench/opponent_color_channel_convert_tb.sv =====
// Testbench for opponent_color_channel_convert: directed and random pixels, checked against
// an in-bench predictor of intensity and the R, G, B, Y opponent channels.
// Depends on occc_pkg and the opponent_color_channel_convert RTL.
module opponent_color_channel_convert_tb;
    import occc_pkg::*;

    localparam int LATENCY      = 16;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_REPORTS  = 10;
    localparam int THR_MAX      = 12240;

    typedef struct packed {
        logic [INT_W-1:0] intensity;
        logic [OPP_W-1:0] red;
        logic [OPP_W-1:0] green;
        logic [OPP_W-1:0] blue;
        logic [OPP_W-1:0] yellow;
    } t_opp_pixel;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [THR_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [CH_W-1:0]  i_red_in;
    logic [CH_W-1:0]  i_green_in;
    logic [CH_W-1:0]  i_blue_in;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [INT_W-1:0] o_intensity_out;
    logic [OPP_W-1:0] o_red_opp;
    logic [OPP_W-1:0] o_green_opp;
    logic [OPP_W-1:0] o_blue_opp;
    logic [OPP_W-1:0] o_yellow_opp;

    t_opp_pixel       pending_channels[$];
    logic [THR_W-1:0] cur_threshold;
    int               error_count;
    int               cycle_count;
    bit               tx_stall_en;
    bit               rx_stall_en;
    int               rx_hold_tokens;
    int               rx_hold_seen;
    int               rx_hold_left;
    int               rx_gap_left;

    opponent_color_channel_convert u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_red_in        (i_red_in),
        .i_green_in      (i_green_in),
        .i_blue_in       (i_blue_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_intensity_out (o_intensity_out),
        .o_red_opp       (o_red_opp),
        .o_green_opp     (o_green_opp),
        .o_blue_opp      (o_blue_opp),
        .o_yellow_opp    (o_yellow_opp)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int opp_quotient(int num, int scale, int sum);
        if (num <= 0 || sum == 0)
            return 0;
        return (num * scale) / sum;
    endfunction

    function automatic t_opp_pixel compute_opponent(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                    logic [CH_W-1:0] b, logic [THR_W-1:0] thr);
        t_opp_pixel res;
        int         sum;
        int         mn;
        sum           = int'(r) + int'(g) + int'(b);
        mn            = (r < g) ? int'(r) : int'(g);
        res           = '0;
        res.intensity = INT_W'((sum * 16) / 3);
        if ((sum * 16) > int'(thr) && sum != 0) begin
            res.red    = OPP_W'(opp_quotient(2 * r - g - b, 6144, sum));
            res.green  = OPP_W'(opp_quotient(2 * g - r - b, 6144, sum));
            res.blue   = OPP_W'(opp_quotient(2 * b - r - g, 6144, sum));
            res.yellow = OPP_W'(opp_quotient(mn - int'(b), 12288, sum));
        end
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Sample handshakes at the rising edge: check results, queue predictions, track the register.
    always @(posedge i_clk) begin
        t_opp_pixel got;
        t_opp_pixel want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_intensity_out, o_red_opp, o_green_opp, o_blue_opp, o_yellow_opp};
                if (pending_channels.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Unexpected item: %h", got);
                end else begin
                    want = pending_channels.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("Mismatch: exp I=%0d R=%0d G=%0d B=%0d Y=%0d",
                                     want.intensity, want.red, want.green, want.blue,
                                     want.yellow,
                                     " got I=%0d R=%0d G=%0d B=%0d Y=%0d",
                                     got.intensity, got.red, got.green,
                                     got.blue, got.yellow);
                    end
                end
            end
            if (i_in_valid && o_in_ready)
                pending_channels = {pending_channels,
                                    compute_opponent(i_red_in, i_green_in, i_blue_in,
                                                     cur_threshold)};
            if (i_cfg_valid && o_cfg_ready)
                cur_threshold = i_cfg_data;
        end
    end

    // Output ready: long hold on request, else random gaps or always ready.
    always @(negedge i_clk) begin
        if (rx_hold_tokens != rx_hold_seen) begin
            rx_hold_seen = rx_hold_tokens;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (!rx_stall_en) begin
            i_out_ready <= 1'b1;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                rx_gap_left = pick_gap();
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
        int gap;
        i_in_valid <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
        gap = 0;
        if (tx_stall_en && $urandom_range(0, 99) < 30)
            gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_channels.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
                                output logic [CH_W-1:0] b);
        int mode;
        int base;
        mode = $urandom_range(0, 99);
        r    = CH_W'($urandom);
        g    = CH_W'($urandom);
        b    = CH_W'($urandom);
        if (mode < 15) begin
            r = CH_W'($urandom_range(0, 15));
            g = CH_W'($urandom_range(0, 15));
            b = CH_W'($urandom_range(0, 15));
        end else if (mode < 30) begin
            base = $urandom_range(1, 254);
            r    = CH_W'(base);
            g    = CH_W'(base + $urandom_range(0, 2) - 1);
            b    = CH_W'(base + $urandom_range(0, 2) - 1);
        end else if (mode < 45) begin
            case ($urandom_range(0, 2))
                0: begin
                    g = g >> 3;
                    b = b >> 3;
                end
                1: begin
                    r = r >> 3;
                    b = b >> 3;
                end
                default: begin
                    r = r >> 3;
                    g = g >> 3;
                end
            endcase
        end else if (mode < 60) begin
            b = b >> 4;
        end
    endtask

    task automatic test_extremes();
        rx_stall_en = 1'b0;
        tx_stall_en = 1'b0;
        write_threshold('0);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd1);
        send_pixel(8'd128, 8'd64, 8'd32);
        send_pixel(8'd200, 8'd200, 8'd10);
        send_pixel(8'd1, 8'd2, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd255);
    endtask

    task automatic test_low_light();
        write_threshold(14'd960);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd30, 8'd20, 8'd11);
        write_threshold(14'd959);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd0, 8'd0, 8'd0);
        write_threshold(THR_W'(THR_MAX));
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd255, 8'd0, 8'd0);
        write_threshold(THR_W'(THR_MAX - 1));
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd254);
    endtask

    task automatic test_random_pixels();
        logic [CH_W-1:0]  r;
        logic [CH_W-1:0]  g;
        logic [CH_W-1:0]  b;
        logic [THR_W-1:0] thr;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: thr = '0;
                1: thr = THR_W'(THR_MAX);
                2: thr = THR_W'($urandom_range(0, 1200));
                default: thr = THR_W'($urandom_range(0, THR_MAX));
            endcase
            rx_stall_en = (phase != 0);
            tx_stall_en = (phase != 0);
            write_threshold(thr);
            for (int n = 0; n < 160; n++) begin
                random_pixel(r, g, b);
                send_pixel(r, g, b);
            end
        end
    endtask

    task automatic test_backpressure();
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        write_threshold(THR_W'($urandom_range(0, 2000)));
        tx_stall_en    = 1'b0;
        rx_stall_en    = 1'b1;
        rx_hold_tokens <= rx_hold_tokens + 1;
        for (int n = 0; n < 80; n++) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_red_in       = '0;
        i_green_in     = '0;
        i_blue_in      = '0;
        i_out_ready    = 1'b0;
        cur_threshold  = '0;
        error_count    = 0;
        cycle_count    = 0;
        tx_stall_en    = 1'b0;
        rx_stall_en    = 1'b0;
        rx_hold_tokens = 0;
        rx_hold_seen   = 0;
        rx_hold_left   = 0;
        rx_gap_left    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_low_light();
        test_random_pixels();
        test_backpressure();
        wait_idle();

        if (error_count == 0 && pending_channels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
